FILE: hdl/double_ended_queue_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the deque core
// Immediate-implication and next-cycle-implication checks with reset gating.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dq_pkg.sv
// ---------------------------------------------------------------------------
// dq_pkg
// Command codes and beat payload types of the deque core.
// ---------------------------------------------------------------------------
package dq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SIZE       = 3'd4,
    CMD_EMPTY      = 3'd5,
    CMD_PEEK_FRONT = 3'd6,
    CMD_PEEK_BACK  = 3'd7
  } dq_cmd_t;

  typedef struct packed {
    dq_cmd_t            command;
    logic signed [31:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic               was_empty;
  } dq_out_t;

  localparam logic signed [31:0] EMPTY_ANSWER = -32'sd1;

endpackage

FILE: hdl/dq_mem.sv
// ---------------------------------------------------------------------------
// dq_mem
// Entry store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module dq_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic signed [31:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic signed [31:0] rd_data
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/double_ended_queue_core.sv
// Path: a result beat is registered in stage 1, then in the output register.
// Throughput: one command per cycle while the result side does not stall;
//   the input stalls only while a result waits in stage 1 behind a stalled
//   output register.
// Pushes produce no result beat. Reset (rst_n low, synchronous) empties the
//   deque at once: head and count go to zero, no clearing pass is needed.
// ---------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 32-bit words in a circular entry store.
// ---------------------------------------------------------------------------
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dq_in_t  in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output dq_out_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  // Pointer state
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Stage 1: command taken, store read in flight
  logic    s1_valid_r, s1_valid_nxt;
  logic    s1_mem_r, s1_mem_nxt;
  dq_out_t s1_imm_r, s1_imm_nxt;

  // Output register
  logic    out_valid_r, out_valid_nxt;
  dq_out_t out_data_r, out_data_nxt;

  // Store ports
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_data;

  logic          accept;
  logic          out_free;
  logic          full;
  logic          empty;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [SW-1:0] back_sum;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] back_idx;
  logic [AW-1:0] tail_idx;
  logic          out_held;
  logic          push_ok;

  // The output register can take a beat when empty or draining this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // Stall input only when a result in stage 1 cannot move forward.
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // Wrap the head one step either way.
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // Slot past the back, and the back slot itself; back_sum stays below 2*DEPTH, tail_sum too unless empty.
  assign back_sum = SW'(head_r) + SW'(count_r);
  assign tail_sum = back_sum - SW'(1);
  assign back_idx = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign tail_idx = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  assign rd_en = accept;

  always_comb begin
    head_nxt          = head_r;
    count_nxt         = count_r;
    wr_en             = 1'b0;
    wr_addr           = back_idx;
    rd_addr           = head_r;
    s1_mem_nxt        = s1_mem_r;
    s1_imm_nxt        = s1_imm_r;
    s1_valid_nxt      = out_free ? 1'b0 : s1_valid_r;

    if (accept) begin
      s1_valid_nxt         = 1'b0;
      s1_mem_nxt           = 1'b0;
      s1_imm_nxt.answer    = EMPTY_ANSWER;
      s1_imm_nxt.was_empty = 1'b0;
      case (in_data.command)
        CMD_PUSH_FRONT: begin
          // Drop the beat when the store is full.
          if (!full) begin
            head_nxt  = head_dec;
            wr_en     = 1'b1;
            wr_addr   = head_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (!full) begin
            wr_en     = 1'b1;
            wr_addr   = back_idx;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_POP_FRONT, CMD_PEEK_FRONT: begin
          s1_valid_nxt = 1'b1;
          if (empty) begin
            s1_imm_nxt.was_empty = 1'b1;
          end else begin
            s1_mem_nxt = 1'b1;
            rd_addr    = head_r;
            if (in_data.command == CMD_POP_FRONT) begin
              head_nxt  = head_inc;
              count_nxt = count_r - CW'(1);
            end
          end
        end
        CMD_POP_BACK, CMD_PEEK_BACK: begin
          s1_valid_nxt = 1'b1;
          if (empty) begin
            s1_imm_nxt.was_empty = 1'b1;
          end else begin
            s1_mem_nxt = 1'b1;
            rd_addr    = tail_idx;
            if (in_data.command == CMD_POP_BACK) begin
              count_nxt = count_r - CW'(1);
            end
          end
        end
        CMD_SIZE: begin
          s1_valid_nxt      = 1'b1;
          s1_imm_nxt.answer = 32'(count_r);
        end
        CMD_EMPTY: begin
          s1_valid_nxt      = 1'b1;
          s1_imm_nxt.answer = empty ? 32'sd1 : 32'sd0;
        end
        default: begin
          s1_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  // Advance stage 1 into the output register; pick store data or the
  // answer formed at accept time.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
      out_data_nxt  = s1_imm_r;
      if (s1_mem_r) begin
        out_data_nxt.answer = rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    s1_mem_r   <= s1_mem_nxt;
    s1_imm_r   <= s1_imm_nxt;
    out_data_r <= out_data_nxt;
  end

  dq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Terms used by the checks below.
  assign out_held = out_valid_r && out_stall;
  assign push_ok  = accept && !full &&
                    (in_data.command == CMD_PUSH_FRONT || in_data.command == CMD_PUSH_BACK);

`include "double_ended_queue_core_assert.svh"

  `DQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "count above depth")
  `DQ_ASSERT_NOW(a_head_bound, clk, rst_n, 1'b1, head_r <= AW'(DEPTH - 1), "head out of range")
  `DQ_ASSERT_NOW(a_stage_hold, clk, rst_n, s1_valid_r && out_held, in_stall, "stage 1 overrun")
  `DQ_ASSERT_NEXT(a_push_count, clk, rst_n, push_ok, count_r == $past(count_r) + CW'(1), "count")

endmodule
